@@ hdl/fcpa_pkg.sv @@
package fcpa_pkg;

	localparam int CHUNK_COUNT = 1024;
	localparam int CHUNK_BYTES = 64;
	localparam int IDX_W       = $clog2(CHUNK_COUNT);
	localparam int LINK_W      = IDX_W + 1;
	localparam int SIZE_W      = 16;
	localparam int CNT_W       = 32;
	localparam int AVAIL_W     = 11;

	localparam logic [LINK_W-1:0]  NULL_LINK   = LINK_W'(CHUNK_COUNT);
	localparam logic [LINK_W-1:0]  HEAD_RESET  = LINK_W'(CHUNK_COUNT - 1);
	localparam logic [IDX_W-1:0]   LAST_IDX    = IDX_W'(CHUNK_COUNT - 1);
	localparam logic [AVAIL_W-1:0] AVAIL_RESET = AVAIL_W'(CHUNK_COUNT);
	localparam logic [SIZE_W-1:0]  SIZE_LIMIT  = SIZE_W'(CHUNK_BYTES);

	typedef enum logic {
		REQ_ALLOC = 1'b0,
		REQ_FREE  = 1'b1
	} req_type_t;

	typedef enum logic [1:0] {
		STS_ALLOC   = 2'd0,
		STS_TOO_BIG = 2'd1,
		STS_EMPTY   = 2'd2,
		STS_FREED   = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		ST_INIT,
		ST_IDLE,
		ST_POP
	} state_t;

	typedef struct packed {
		req_type_t         req_type;
		logic [SIZE_W-1:0] req_size;
		logic [IDX_W-1:0]  chunk_index;
	} req_t;

	typedef struct packed {
		status_t            status;
		logic [IDX_W-1:0]   granted_index;
		logic [CNT_W-1:0]   alloc_count;
		logic [CNT_W-1:0]   free_count;
		logic [AVAIL_W-1:0] available_count;
		logic [CNT_W-1:0]   wasted_bytes;
	} res_t;

	typedef struct packed {
		logic    init_wr;
		logic    free_push;
		logic    alloc_issue;
		logic    alloc_finish;
		logic    res_valid;
		status_t res_status;
	} ctrl_t;

	typedef struct packed {
		logic init_last;
		logic size_big;
		logic head_null;
	} stat_t;

endpackage

@@ hdl/fixed_chunk_pool_allocator.sv @@
// channel   signals                  handshake
// request   start, busy, req         taken when start && !busy
// result    done, res                one word per request, valid while done is high
//
// After reset, busy stays high while the link memory is initialized.
// Free, oversized or empty-pool requests: result the next cycle, busy never rises.
// Allocate: a registered read of the head's link, then busy in the pop state.
// The result is registered and goes out whatever the receiver does; it cannot stall.
module fixed_chunk_pool_allocator (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	output logic            busy,
	input  fcpa_pkg::req_t  req,
	output logic            done,
	output fcpa_pkg::res_t  res
);

	fcpa_pkg::ctrl_t ctrl;
	fcpa_pkg::stat_t stat;

	fcpa_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.req    (req),
		.stat   (stat),
		.busy   (busy),
		.ctrl   (ctrl)
	);

	fcpa_dpath u_dpath (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.ctrl   (ctrl),
		.stat   (stat),
		.done   (done),
		.res    (res)
	);

endmodule

@@ hdl/fcpa_ctrl.sv @@
module fcpa_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  fcpa_pkg::req_t    req,
	input  fcpa_pkg::stat_t   stat,
	output logic              busy,
	output fcpa_pkg::ctrl_t   ctrl
);

	fcpa_pkg::state_t state_q;
	fcpa_pkg::state_t state_d;
	logic             take;

	assign take = start && (state_q == fcpa_pkg::ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fcpa_pkg::ST_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			fcpa_pkg::ST_INIT: begin
				if (stat.init_last) begin
					state_d = fcpa_pkg::ST_IDLE;
				end
			end
			fcpa_pkg::ST_IDLE: begin
				if (take && req.req_type == fcpa_pkg::REQ_ALLOC && !stat.size_big
						&& !stat.head_null) begin
					state_d = fcpa_pkg::ST_POP;
				end
			end
			fcpa_pkg::ST_POP: begin
				state_d = fcpa_pkg::ST_IDLE;
			end
			default: begin
				state_d = fcpa_pkg::ST_INIT;
			end
		endcase
	end

	always_comb begin
		busy              = 1'b1;
		ctrl              = '0;
		ctrl.res_status   = fcpa_pkg::STS_ALLOC;
		unique case (state_q)
			fcpa_pkg::ST_INIT: begin
				ctrl.init_wr = 1'b1;
			end
			fcpa_pkg::ST_IDLE: begin
				busy = 1'b0;
				if (take) begin
					if (req.req_type == fcpa_pkg::REQ_FREE) begin
						ctrl.free_push  = 1'b1;
						ctrl.res_valid  = 1'b1;
						ctrl.res_status = fcpa_pkg::STS_FREED;
					end else if (stat.size_big) begin
						ctrl.res_valid  = 1'b1;
						ctrl.res_status = fcpa_pkg::STS_TOO_BIG;
					end else if (stat.head_null) begin
						ctrl.res_valid  = 1'b1;
						ctrl.res_status = fcpa_pkg::STS_EMPTY;
					end else begin
						ctrl.alloc_issue = 1'b1;
					end
				end
			end
			fcpa_pkg::ST_POP: begin
				ctrl.alloc_finish = 1'b1;
				ctrl.res_valid    = 1'b1;
				ctrl.res_status   = fcpa_pkg::STS_ALLOC;
			end
			default: begin
				busy = 1'b1;
			end
		endcase
	end

	a_pop_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == fcpa_pkg::ST_POP |=> state_q == fcpa_pkg::ST_IDLE)
		else $error("pop state held longer than one cycle");

	a_issue_then_finish: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.alloc_issue |=> ctrl.alloc_finish)
		else $error("alloc issue not followed by finish");

	a_one_command: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({ctrl.init_wr, ctrl.free_push, ctrl.alloc_issue, ctrl.alloc_finish}))
		else $error("more than one datapath command");

endmodule

@@ hdl/fcpa_dpath.sv @@
module fcpa_dpath (
	input  logic              clk,
	input  logic              arst_n,
	input  fcpa_pkg::req_t    req,
	input  fcpa_pkg::ctrl_t   ctrl,
	output fcpa_pkg::stat_t   stat,
	output logic              done,
	output fcpa_pkg::res_t    res
);

	logic [fcpa_pkg::LINK_W-1:0] next_link_q [fcpa_pkg::CHUNK_COUNT];
	logic [fcpa_pkg::LINK_W-1:0] rd_q;
	logic [fcpa_pkg::IDX_W-1:0]  init_q;
	logic [fcpa_pkg::IDX_W-1:0]  gnt_q;

	logic [fcpa_pkg::LINK_W-1:0]  head_q, head_d;
	logic [fcpa_pkg::CNT_W-1:0]   alloc_q, alloc_d;
	logic [fcpa_pkg::CNT_W-1:0]   free_q, free_d;
	logic [fcpa_pkg::CNT_W-1:0]   waste_q, waste_d;
	logic [fcpa_pkg::AVAIL_W-1:0] avail_q, avail_d;

	logic                        wr_en;
	logic [fcpa_pkg::IDX_W-1:0]  wr_addr;
	logic [fcpa_pkg::LINK_W-1:0] wr_data;
	logic [fcpa_pkg::LINK_W-1:0] init_data;
	logic [fcpa_pkg::SIZE_W-1:0] slack;

	fcpa_pkg::res_t res_q;
	logic           done_q;

	assign stat.init_last = (init_q == fcpa_pkg::LAST_IDX);
	assign stat.size_big  = (req.req_size > fcpa_pkg::SIZE_LIMIT);
	assign stat.head_null = (head_q >= fcpa_pkg::NULL_LINK);

	// entry i links to i-1, entry 0 ends the list
	assign init_data = (init_q == '0) ? fcpa_pkg::NULL_LINK
		: ({1'b0, init_q} - fcpa_pkg::LINK_W'(1));

	assign wr_en   = ctrl.init_wr || ctrl.free_push;
	assign wr_addr = ctrl.init_wr ? init_q : req.chunk_index;
	assign wr_data = ctrl.init_wr ? init_data : head_q;

	assign slack = fcpa_pkg::SIZE_LIMIT - req.req_size;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			next_link_q[wr_addr] <= wr_data;
		end
		if (ctrl.alloc_issue) begin
			rd_q  <= next_link_q[head_q[fcpa_pkg::IDX_W-1:0]];
			gnt_q <= head_q[fcpa_pkg::IDX_W-1:0];
		end
	end

	always_comb begin
		head_d  = head_q;
		alloc_d = alloc_q;
		free_d  = free_q;
		waste_d = waste_q;
		avail_d = avail_q;
		if (ctrl.free_push) begin
			head_d  = {1'b0, req.chunk_index};
			free_d  = free_q + fcpa_pkg::CNT_W'(1);
			avail_d = avail_q + fcpa_pkg::AVAIL_W'(1);
		end
		if (ctrl.alloc_issue) begin
			alloc_d = alloc_q + fcpa_pkg::CNT_W'(1);
			waste_d = waste_q + fcpa_pkg::CNT_W'(slack);
			avail_d = avail_q - fcpa_pkg::AVAIL_W'(1);
		end
		if (ctrl.alloc_finish) begin
			head_d = rd_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_q  <= '0;
			head_q  <= fcpa_pkg::HEAD_RESET;
			alloc_q <= '0;
			free_q  <= '0;
			waste_q <= '0;
			avail_q <= fcpa_pkg::AVAIL_RESET;
			done_q  <= 1'b0;
		end else begin
			if (ctrl.init_wr) begin
				init_q <= init_q + fcpa_pkg::IDX_W'(1);
			end
			head_q  <= head_d;
			alloc_q <= alloc_d;
			free_q  <= free_d;
			waste_q <= waste_d;
			avail_q <= avail_d;
			done_q  <= ctrl.res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.res_valid) begin
			res_q.status          <= ctrl.res_status;
			res_q.granted_index   <= ctrl.alloc_finish ? gnt_q : '0;
			res_q.alloc_count     <= alloc_d;
			res_q.free_count      <= free_d;
			res_q.available_count <= avail_d;
			res_q.wasted_bytes    <= waste_d;
		end
	end

	assign done = done_q;
	assign res  = res_q;

	a_finish_grants: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.alloc_finish |=> done_q && res_q.status == fcpa_pkg::STS_ALLOC)
		else $error("pop did not deliver a grant");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.alloc_issue |-> head_q < fcpa_pkg::NULL_LINK)
		else $error("pop issued on an empty list");

endmodule
